@@ rtl/core/rtmc_pkg.sv @@
// Shared types and constants of the range table membership counter.
package rtmc_pkg;

  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int HIT_W     = 32;
  localparam int ENTRIES_W = 9;
  localparam int OUT_W     = ((HIT_W + ENTRIES_W + 7) / 8) * 8;
  localparam int OUT_PAD   = OUT_W - HIT_W - ENTRIES_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } rtmc_ctl_t;

endpackage

@@ rtl/core/rtmc_bound_table.sv @@
// Range bound memory with registered read port and membership compare.
module rtmc_bound_table import rtmc_pkg::*; #(
  parameter int DEPTH   = 256,
  parameter int ID_BITS = 52,
  parameter int AW      = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rtmc_ctl_t          ctl,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ID_BITS-1:0] wr_low,
  input  logic [ID_BITS-1:0] wr_high,
  input  logic [AW-1:0]      rd_addr,
  input  logic [ID_BITS-1:0] item_id,
  output logic               match
);

  logic [2*ID_BITS-1:0] mem_r [DEPTH];
  logic [2*ID_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [ID_BITS-1:0]   rd_low;
  logic [ID_BITS-1:0]   rd_high;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= {wr_high, wr_low};
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= ctl.rd_en;
    end
  end

  assign rd_low  = rd_data_r[ID_BITS-1:0];
  assign rd_high = rd_data_r[2*ID_BITS-1:ID_BITS];
  assign match   = rd_vld_r && (rd_low <= item_id) && (item_id <= rd_high);

endmodule

@@ rtl/core/range_table_membership_counter_top.sv @@
// Range table membership counter: stores inclusive ranges and counts query hits.
//
// The input channel carries one operation per beat: in_tuser selects insert,
// query or clear, and in_tdata carries the range bounds and the identifier.
// Every insert, query and clear returns exactly one beat on the output
// channel with a status code in out_tuser and the hit total and the number
// of stored ranges in out_tdata. The unused operation code is accepted and
// returns nothing. Items are processed one at a time.
// Insert and clear pass from acceptance through the response state into the
// output register. A query reads the stored ranges from the bound memory, one
// entry per cycle through its single read port, then passes the last-compare
// and response states (an empty table goes straight to the response state);
// the next beat is taken once the result has moved to the output register.
// A finished result waits in the output register while the receiver stalls,
// and the next item is already accepted meanwhile; its own result holds
// until the output register frees up.
// Reset empties the table and zeroes the hit count with no clearing pass,
// since only entries below the fill count are ever read.
module range_table_membership_counter_top import rtmc_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int ID_BITS     = 52
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // range_low, range_high, item_id
  input  logic [((3*ID_BITS+7)/8)*8-1:0]       in_tdata,
  // operation
  input  logic [OP_W-1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // hit_total, entries_used
  output logic [OUT_W-1:0]                     out_tdata,
  // status
  output logic [STATUS_W-1:0]                  out_tuser
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [HIT_W-1:0]    hits_r, hits_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [AW-1:0]       scan_addr_r, scan_addr_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic                hit_acc_r, hit_acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic               in_acc;
  logic               out_free;
  logic [ID_BITS-1:0] in_low;
  logic [ID_BITS-1:0] in_high;
  logic [ID_BITS-1:0] in_id;
  logic               full;
  logic               bad;
  logic               ins_ok;
  logic               clr_acc;
  logic               scan_last;
  logic               match;
  rtmc_ctl_t          tbl_ctl;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_low    = in_tdata[ID_BITS-1:0];
  assign in_high   = in_tdata[2*ID_BITS-1:ID_BITS];
  assign in_id     = in_tdata[3*ID_BITS-1:2*ID_BITS];
  assign full      = (cnt_r == CW'(TABLE_DEPTH));
  assign bad       = (in_low == '0) || (in_low > in_high);
  assign ins_ok    = in_acc && (in_tuser == OP_INSERT) && !full && !bad;
  assign clr_acc   = in_acc && (in_tuser == OP_CLEAR);
  assign scan_last = ((CW'(scan_addr_r) + CW'(1)) == cnt_r);

  assign tbl_ctl.wr_en = ins_ok;
  assign tbl_ctl.rd_en = (state_r == S_SCAN);

  rtmc_bound_table #(
    .DEPTH   (TABLE_DEPTH),
    .ID_BITS (ID_BITS),
    .AW      (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_low  (in_low),
    .wr_high (in_high),
    .rd_addr (scan_addr_r),
    .item_id (id_r),
    .match   (match)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    hits_nxt       = hits_r;
    status_nxt     = status_r;
    scan_addr_nxt  = scan_addr_r;
    id_nxt         = id_r;
    hit_acc_nxt    = hit_acc_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            OP_INSERT: begin
              state_nxt = S_RESP;
              if (full) begin
                status_nxt = ST_FULL;
              end else if (bad) begin
                status_nxt = ST_BAD;
              end else begin
                cnt_nxt    = cnt_r + CW'(1);
                status_nxt = ST_INSERTED;
              end
            end
            OP_QUERY: begin
              id_nxt        = in_id;
              hit_acc_nxt   = 1'b0;
              scan_addr_nxt = '0;
              if (cnt_r == '0) begin
                status_nxt = ST_MISS;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: begin
              cnt_nxt    = '0;
              hits_nxt   = '0;
              status_nxt = ST_CLEARED;
              state_nxt  = S_RESP;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        hit_acc_nxt   = hit_acc_r | match;
        scan_addr_nxt = scan_addr_r + AW'(1);
        if (scan_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_RESP;
        if (hit_acc_r || match) begin
          status_nxt = ST_HIT;
          if (hits_r != '1) begin
            hits_nxt = hits_r + HIT_W'(1);
          end
        end else begin
          status_nxt = ST_MISS;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = {{OUT_PAD{1'b0}}, ENTRIES_W'(cnt_r), hits_r};
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    scan_addr_r  <= scan_addr_nxt;
    id_r         <= id_nxt;
    hit_acc_r    <= hit_acc_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("Fill count exceeds the table depth.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(scan_addr_r) < cnt_r))
    else $error("Scan address is beyond the stored ranges.");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_ctl.wr_en |-> !tbl_ctl.rd_en)
    else $error("Table write overlaps a scan read.");

  a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
    clr_acc |=> (cnt_r == '0) && (hits_r == '0))
    else $error("Clear did not empty the table and the hit count.");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !clr_acc) |=> (hits_r >= $past(hits_r)))
    else $error("Hit count decreased without a clear.");

endmodule

@@ sim/rtmc_checker.sv @@
// Checker for the range table membership counter: tracks the range table, predicts and compares.
`timescale 1ns / 1ps

module rtmc_checker import rtmc_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int ID_BITS     = 52
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [((3*ID_BITS+7)/8)*8-1:0]   in_tdata,
  input  logic [OP_W-1:0]                  in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [OUT_W-1:0]                 out_tdata,
  input  logic [STATUS_W-1:0]              out_tuser,
  input  logic                             end_check,
  output int                               fail_count,
  output int                               outstanding
);

  typedef logic [ID_BITS-1:0] id_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [HIT_W-1:0]     hit_total;
    logic [ENTRIES_W-1:0] entries_used;
  } status_beat_t;

  localparam logic [HIT_W-1:0] HIT_SATURATED = {HIT_W{1'b1}};

  id_t                  range_lo_mem [TABLE_DEPTH];
  id_t                  range_hi_mem [TABLE_DEPTH];
  logic [ENTRIES_W-1:0] range_fill;
  logic [HIT_W-1:0]     hit_count;
  status_beat_t         pending_status [$];
  logic                 end_reported;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    end_reported = 1'b0;
    range_fill   = '0;
    hit_count    = '0;
  end

  function automatic logic id_in_table(id_t id);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k < int'(range_fill) && range_lo_mem[k] <= id && id <= range_hi_mem[k]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    status_beat_t got;
    status_beat_t want;
    status_beat_t pred;
    logic         produce;
    id_t          lo;
    id_t          hi;
    id_t          qid;
    if (!rst_n) begin
      range_fill = '0;
      hit_count  = '0;
      pending_status.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status       = out_tuser;
        got.hit_total    = out_tdata[HIT_W-1:0];
        got.entries_used = out_tdata[HIT_W +: ENTRIES_W];
        if (pending_status.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d, hit_total %0d, entries_used %0d",
                   $time, got.status, got.hit_total, got.entries_used);
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
          if (got.hit_total !== want.hit_total) begin
            $display("%0t: hit_total mismatch, expected %0d, actual %0d",
                     $time, want.hit_total, got.hit_total);
            fail_count++;
          end
          if (got.entries_used !== want.entries_used) begin
            $display("%0t: entries_used mismatch, expected %0d, actual %0d",
                     $time, want.entries_used, got.entries_used);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        lo      = in_tdata[ID_BITS-1:0];
        hi      = in_tdata[2*ID_BITS-1:ID_BITS];
        qid     = in_tdata[3*ID_BITS-1:2*ID_BITS];
        produce = 1'b1;
        case (in_tuser)
          OP_INSERT: begin
            if (int'(range_fill) >= TABLE_DEPTH) begin
              pred.status = ST_FULL;
            end else if (lo == '0 || lo > hi) begin
              pred.status = ST_BAD;
            end else begin
              range_lo_mem[range_fill] = lo;
              range_hi_mem[range_fill] = hi;
              range_fill++;
              pred.status = ST_INSERTED;
            end
          end
          OP_QUERY: begin
            if (id_in_table(qid)) begin
              if (hit_count != HIT_SATURATED) hit_count++;
              pred.status = ST_HIT;
            end else begin
              pred.status = ST_MISS;
            end
          end
          OP_CLEAR: begin
            range_fill  = '0;
            hit_count   = '0;
            pred.status = ST_CLEARED;
          end
          default: begin
            produce = 1'b0;
          end
        endcase
        if (produce) begin
          pred.hit_total    = hit_count;
          pred.entries_used = range_fill;
          pending_status    = {pending_status, pred};
        end
      end
      if (end_check && !end_reported) begin
        end_reported = 1'b1;
        if (pending_status.size() != 0) begin
          $display("%0t: %0d expected result beats never arrived, expected %0d, actual 0",
                   $time, pending_status.size(), pending_status.size());
          fail_count++;
        end
      end
    end
    outstanding = pending_status.size();
  end

endmodule

@@ sim/range_table_membership_counter_top_tb.sv @@
// Testbench top for the range table membership counter: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module range_table_membership_counter_top_tb import rtmc_pkg::*;;

  localparam int TABLE_DEPTH    = 256;
  localparam int ID_BITS        = 52;
  localparam int IN_W           = ((3*ID_BITS+7)/8)*8;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int STALL_LIMIT    = 5000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic [ID_BITS-1:0] id_t;
  localparam id_t ID_MAX = {ID_BITS{1'b1}};
  localparam id_t ID_ONE = id_t'(1);

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic [OP_W-1:0]   in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic              end_check;
  int                fail_count;
  int                outstanding;

  int idle_pct;
  int stall_pct;
  int items_sent;
  int n_insert;
  int n_query;
  int n_clear;
  int n_ignored;
  int n_fills;

  id_t stim_lo [$];
  id_t stim_hi [$];

  range_table_membership_counter_top #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rtmc_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .end_check   (end_check),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic id_t rand_id();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return id_t'(r >> $urandom_range(12, 63));
  endfunction

  function automatic id_t pick_query_id();
    int   idx;
    id_t  lo;
    id_t  hi;
    logic [63:0] span;
    if (stim_lo.size() == 0 || $urandom_range(0, 3) == 0) return rand_id();
    idx  = $urandom_range(0, stim_lo.size() - 1);
    lo   = stim_lo[idx];
    hi   = stim_hi[idx];
    span = 64'(hi - lo) + 64'd1;
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return lo - ID_ONE;
      3: return hi + ID_ONE;
      default: return lo + id_t'({$urandom, $urandom} % span);
    endcase
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input id_t lo, input id_t hi,
                         input id_t id);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {{(IN_W-3*ID_BITS){1'b0}}, id, hi, lo};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    case (op)
      OP_INSERT: n_insert++;
      OP_QUERY:  n_query++;
      OP_CLEAR:  n_clear++;
      default:   n_ignored++;
    endcase
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_CLEAR) begin
      stim_lo.delete();
      stim_hi.delete();
    end
  endtask

  task automatic insert_range(input logic good);
    id_t lo;
    id_t hi;
    id_t a;
    id_t b;
    if (good) begin
      lo = rand_id();
      if (lo == '0) lo = ID_ONE;
      b  = rand_id() >> $urandom_range(0, ID_BITS - 1);
      hi = (lo > ID_MAX - b) ? ID_MAX : lo + b;
    end else if ($urandom_range(0, 2) == 0) begin
      lo = '0;
      hi = rand_id();
    end else begin
      a = rand_id();
      b = rand_id();
      if (a == b) b = a - ID_ONE;
      lo = (a > b) ? a : b;
      hi = (a > b) ? b : a;
    end
    send_op(OP_INSERT, lo, hi, rand_id());
    if (good && stim_lo.size() < TABLE_DEPTH) begin
      stim_lo = {stim_lo, lo};
      stim_hi = {stim_hi, hi};
    end
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic run_episode(input int n_ranges);
    int r;
    send_op(OP_CLEAR, rand_id(), rand_id(), rand_id());
    repeat (n_ranges) begin
      insert_range($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 5) == 0) send_op(OP_QUERY, rand_id(), rand_id(), pick_query_id());
    end
    repeat ($urandom_range(4, 30)) begin
      r = $urandom_range(0, 19);
      if (r < 14) send_op(OP_QUERY, rand_id(), rand_id(), pick_query_id());
      else if (r < 16) insert_range(1'b1);
      else if (r < 17) insert_range(1'b0);
      else if (r < 18) send_op(OP_UNUSED, rand_id(), rand_id(), rand_id());
      else if (r < 19) send_op(2'($urandom_range(0, 3)), rand_id(), rand_id(), rand_id());
      else send_op(OP_CLEAR, rand_id(), rand_id(), rand_id());
    end
  endtask

  initial begin
    int phase;
    int last_phase;
    int base_items;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_INSERT;
    end_check  = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    items_sent = 0;
    n_insert   = 0;
    n_query    = 0;
    n_clear    = 0;
    n_ignored  = 0;
    n_fills    = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_op(OP_QUERY,  rand_id(), rand_id(), '0);
    send_op(OP_INSERT, '0, id_t'(5), rand_id());
    send_op(OP_INSERT, id_t'(10), id_t'(9), rand_id());
    send_op(OP_INSERT, ID_ONE, ID_ONE, rand_id());
    send_op(OP_INSERT, ID_MAX, ID_MAX, rand_id());
    send_op(OP_INSERT, id_t'(100), id_t'(200), ID_MAX);
    send_op(OP_QUERY,  ID_MAX, '0, '0);
    send_op(OP_QUERY,  rand_id(), rand_id(), ID_ONE);
    send_op(OP_QUERY,  rand_id(), rand_id(), id_t'(2));
    send_op(OP_QUERY,  rand_id(), rand_id(), id_t'(99));
    send_op(OP_QUERY,  rand_id(), rand_id(), id_t'(100));
    send_op(OP_QUERY,  rand_id(), rand_id(), id_t'(200));
    send_op(OP_QUERY,  rand_id(), rand_id(), id_t'(201));
    send_op(OP_QUERY,  rand_id(), rand_id(), ID_MAX);
    send_op(OP_QUERY,  rand_id(), rand_id(), ID_MAX - ID_ONE);
    send_op(OP_UNUSED, ID_MAX, ID_MAX, ID_MAX);
    send_op(OP_CLEAR,  ID_MAX, ID_MAX, ID_MAX);
    send_op(OP_QUERY,  rand_id(), rand_id(), ID_ONE);
    send_op(OP_INSERT, ID_ONE, ID_MAX, '0);
    send_op(OP_QUERY,  rand_id(), rand_id(), rand_id() | ID_ONE);
    send_op(OP_QUERY,  rand_id(), rand_id(), '0);
    send_op(OP_CLEAR,  '0, '0, '0);

    base_items = items_sent;
    last_phase = -1;
    while (items_sent - base_items < RANDOM_ITEMS) begin
      phase = ((items_sent - base_items) / 180) % 4;
      if (phase != last_phase) begin
        wait_drained();
        idle_pct   = (phase == 1) ? 49 : (phase == 3) ? 36 : 0;
        stall_pct  = (phase == 2) ? 49 : (phase == 3) ? 36 : 0;
        last_phase = phase;
      end
      if (n_fills < 2 && items_sent - base_items >= 300 + 550 * n_fills) begin
        run_episode(TABLE_DEPTH + TABLE_DEPTH / 4);
        n_fills++;
      end else begin
        run_episode($urandom_range(1, 12));
      end
    end

    wait_drained();
    repeat (TABLE_DEPTH + 8) @(negedge clk);
    end_check = 1'b1;
    repeat (2) @(negedge clk);
    $display("Sent %0d beats: %0d inserts, %0d queries, %0d clears, %0d unused codes.",
             items_sent + n_ignored, n_insert, n_query, n_clear, n_ignored);
    $display("The range table was filled to capacity %0d times under four pacing phases.",
             n_fills);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rtmc_pkg.sv
rtl/core/rtmc_bound_table.sv
rtl/core/range_table_membership_counter_top.sv
sim/rtmc_checker.sv
sim/range_table_membership_counter_top_tb.sv
